// ----- src/gti_pkg.sv -----
package gti_pkg;

  localparam int LEVEL_COUNT_DEF = 16;

  localparam int LAT_W   = 9;
  localparam int LON_W   = 16;
  localparam int LEVEL_W = 4;
  localparam int ILAT_W  = 8;
  localparam int ILON_W  = 9;
  localparam int TW_W    = 9;
  localparam int WEXP_W  = 5;
  localparam int ADJ_W   = 7;

  localparam int LAT_COUNT = 180;
  localparam int LON_COUNT = 360;
  localparam int LAT_OFFSET = 90;
  localparam int LAT_POLE = 90;
  localparam int LAT_POLE_FOLD = 89;

  localparam int BAND_2 = 83;
  localparam int BAND_4 = 86;
  localparam int BAND_8 = 88;
  localparam int BAND_POLE = 89;
  localparam int POLE_WIDTH = 360;

  // Bias that lifts any 16-bit longitude to a positive multiple-of-360 offset.
  localparam int LON_BIAS = 33120;
  localparam int LON_RECIP_SHIFT = 24;
  localparam int LON_RECIP = 46604;
  localparam int TEN_RECIP_SHIFT = 12;
  localparam int TEN_RECIP = 410;
  localparam int CHUNK = 10;

  typedef struct packed {
    logic                  loc_valid;
    logic [ILAT_W-1:0]     tile_lat;
    logic [ILON_W-1:0]     tile_lon;
    logic [TW_W-1:0]       tile_width;
    logic [ILAT_W-1:0]     chunk_lat;
    logic [ILON_W-1:0]     chunk_lon;
    logic [LEVEL_W-1:0]    map_height_log2;
    logic [WEXP_W-1:0]     map_width_log2;
  } result_t;

  // Rounded log2 of cos(latitude) times tile width, indexed by internal latitude.
  localparam logic signed [ADJ_W-1:0] WIDTH_EXP_ADJ [LAT_COUNT] = '{
    -7'sd46, -7'sd3, -7'sd3, -7'sd2, -7'sd3, -7'sd3, -7'sd2, -7'sd3, -7'sd3, -7'sd3,
    -7'sd3, -7'sd2, -7'sd2, -7'sd2, -7'sd2, -7'sd2, -7'sd2, -7'sd2, -7'sd2, -7'sd2,
    -7'sd2, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1,
    -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1,
    -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, 7'sd0, 7'sd0, 7'sd0, 7'sd0,
    7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0,
    7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0,
    7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0,
    7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0,
    7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0,
    7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0,
    7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0,
    7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0,
    7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1,
    -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1,
    -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1,
    -7'sd2, -7'sd2, -7'sd2, -7'sd2, -7'sd2, -7'sd2, -7'sd2, -7'sd2, -7'sd2, -7'sd2,
    -7'sd3, -7'sd3, -7'sd3, -7'sd2, -7'sd2, -7'sd3, -7'sd2, -7'sd2, -7'sd2, 7'sd3
  };

endpackage

// ----- src/geo_tile_index_and_map_size.sv -----
// A result passes through the input register and then the result register before it
// appears on the output port.
// Throughput: one location per cycle while out_ready is high, set by the input register
// and result register pair around a single pass of combinational logic.
// A waiting result blocks input only when the input register also holds an item.
// Reset clears only the valid flags of both register stages; the data registers are not reset.
module geo_tile_index_and_map_size #(
  parameter int LEVEL_COUNT = gti_pkg::LEVEL_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [gti_pkg::LAT_W-1:0]   lat_deg,
  input  logic signed [gti_pkg::LON_W-1:0]   lon_deg,
  input  logic                               standard_form,
  input  logic [gti_pkg::LEVEL_W-1:0]        map_level,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               loc_valid,
  output logic [gti_pkg::ILAT_W-1:0]         tile_lat,
  output logic [gti_pkg::ILON_W-1:0]         tile_lon,
  output logic [gti_pkg::TW_W-1:0]           tile_width,
  output logic [gti_pkg::ILAT_W-1:0]         chunk_lat,
  output logic [gti_pkg::ILON_W-1:0]         chunk_lon,
  output logic [gti_pkg::LEVEL_W-1:0]        map_height_log2,
  output logic [gti_pkg::WEXP_W-1:0]         map_width_log2
);

  logic                              stage_valid;
  logic signed [gti_pkg::LAT_W-1:0]  stage_lat;
  logic signed [gti_pkg::LON_W-1:0]  stage_lon;
  logic                              stage_std;
  logic [gti_pkg::LEVEL_W-1:0]       stage_level;
  logic                              stage_ready;
  gti_pkg::result_t                  calc_result;
  gti_pkg::result_t                  result;

  assign stage_ready = !out_valid || out_ready;
  assign in_ready = !stage_valid || stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_lat <= lat_deg;
      stage_lon <= lon_deg;
      stage_std <= standard_form;
      stage_level <= map_level;
    end
  end

  gti_calc #(
    .LEVEL_COUNT(LEVEL_COUNT)
  ) u_calc (
    .lat_deg(stage_lat),
    .lon_deg(stage_lon),
    .standard_form(stage_std),
    .map_level(stage_level),
    .result(calc_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_ready) begin
      out_valid <= stage_valid;
    end
    if (stage_valid && stage_ready) begin
      result <= calc_result;
    end
  end

  assign loc_valid = result.loc_valid;
  assign tile_lat = result.tile_lat;
  assign tile_lon = result.tile_lon;
  assign tile_width = result.tile_width;
  assign chunk_lat = result.chunk_lat;
  assign chunk_lon = result.chunk_lon;
  assign map_height_log2 = result.map_height_log2;
  assign map_width_log2 = result.map_width_log2;

endmodule

// ----- src/gti_calc.sv -----
module gti_calc #(
  parameter int LEVEL_COUNT = gti_pkg::LEVEL_COUNT_DEF
) (
  input  logic signed [gti_pkg::LAT_W-1:0]   lat_deg,
  input  logic signed [gti_pkg::LON_W-1:0]   lon_deg,
  input  logic                               standard_form,
  input  logic [gti_pkg::LEVEL_W-1:0]        map_level,
  output gti_pkg::result_t                   result
);

  localparam logic [gti_pkg::LEVEL_W-1:0] LEVEL_MAX = gti_pkg::LEVEL_W'(LEVEL_COUNT - 1);

  logic signed [gti_pkg::LAT_W:0]   lat_fold;
  logic signed [gti_pkg::LAT_W:0]   lat_int;
  logic signed [gti_pkg::LON_W+1:0] lon_biased;
  logic [gti_pkg::LON_W:0]          lon_u;
  logic [gti_pkg::LON_W+16:0]       lon_prod;
  logic [7:0]                       lon_q;
  logic [gti_pkg::LON_W:0]          lon_q360;
  logic [gti_pkg::LON_W:0]          lon_rem;
  logic                             lat_ok;
  logic                             lon_ok;
  logic [gti_pkg::ILAT_W-1:0]       ilat;
  logic [gti_pkg::ILON_W-1:0]       ilon;
  logic [6:0]                       band;
  logic [gti_pkg::TW_W-1:0]         width;
  logic [gti_pkg::ILON_W-1:0]       tlon;
  logic [gti_pkg::ILAT_W+8:0]       clat_prod;
  logic [gti_pkg::ILON_W+8:0]       clon_prod;
  logic [4:0]                       clat_q;
  logic [5:0]                       clon_q;
  logic [gti_pkg::LEVEL_W-1:0]      level;
  logic signed [7:0]                wsum;

  always_comb begin
    lat_fold = (lat_deg == gti_pkg::LAT_W'(gti_pkg::LAT_POLE))
             ? 10'(signed'(gti_pkg::LAT_POLE_FOLD))
             : 10'(lat_deg);
    lat_int = standard_form ? 10'(lat_fold + 10'(signed'(gti_pkg::LAT_OFFSET))) : 10'(lat_deg);
    lat_ok = (lat_int >= 0) && (lat_int < 10'(signed'(gti_pkg::LAT_COUNT)));

    lon_biased = 18'(lon_deg) + 18'(signed'(gti_pkg::LON_BIAS));
    lon_u = lon_biased[gti_pkg::LON_W:0];
    lon_prod = 33'(lon_u) * 33'(gti_pkg::LON_RECIP);
    lon_q = lon_prod[gti_pkg::LON_RECIP_SHIFT +: 8];
    lon_q360 = (17'(lon_q) << 8) + (17'(lon_q) << 6) + (17'(lon_q) << 5) + (17'(lon_q) << 3);
    lon_rem = lon_u - lon_q360;

    lon_ok = standard_form
           || ((lon_deg >= 0) && (lon_deg < 16'(signed'(gti_pkg::LON_COUNT))));
    ilat = lat_int[gti_pkg::ILAT_W-1:0];
    ilon = standard_form ? lon_rem[gti_pkg::ILON_W-1:0] : lon_deg[gti_pkg::ILON_W-1:0];

    band = (ilat >= 8'(gti_pkg::LAT_OFFSET))
         ? 7'(ilat - 8'(gti_pkg::LAT_OFFSET))
         : 7'(8'(gti_pkg::LAT_OFFSET - 1) - ilat);
    if (band < 7'(gti_pkg::BAND_2)) begin
      width = 9'd1;
    end else if (band < 7'(gti_pkg::BAND_4)) begin
      width = 9'd2;
    end else if (band < 7'(gti_pkg::BAND_8)) begin
      width = 9'd4;
    end else if (band < 7'(gti_pkg::BAND_POLE)) begin
      width = 9'd8;
    end else begin
      width = 9'(gti_pkg::POLE_WIDTH);
    end

    // The polar tile spans all longitudes, so its west edge is always zero.
    tlon = (width == 9'(gti_pkg::POLE_WIDTH)) ? '0 : (ilon & ~(width - 9'd1));

    clat_prod = 17'(ilat) * 17'(gti_pkg::TEN_RECIP);
    clon_prod = 18'(tlon) * 18'(gti_pkg::TEN_RECIP);
    clat_q = clat_prod[gti_pkg::TEN_RECIP_SHIFT +: 5];
    clon_q = clon_prod[gti_pkg::TEN_RECIP_SHIFT +: 6];

    level = (map_level > LEVEL_MAX) ? LEVEL_MAX : map_level;
    wsum = $signed({4'b0000, level}) + 8'(gti_pkg::WIDTH_EXP_ADJ[ilat]);

    result = '0;
    if (lat_ok && lon_ok) begin
      result.loc_valid = 1'b1;
      result.tile_lat = ilat;
      result.tile_lon = tlon;
      result.tile_width = width;
      result.chunk_lat = 8'(clat_q) * 8'(gti_pkg::CHUNK);
      result.chunk_lon = 9'(clon_q) * 9'(gti_pkg::CHUNK);
      result.map_height_log2 = level;
      result.map_width_log2 = (wsum < 0) ? '0 : wsum[gti_pkg::WEXP_W-1:0];
    end
  end

endmodule
